// ----- hw/rtl/ted_pkg.sv -----
// Shared types and constants for the text encoding detector.
package ted_pkg;

    // Number of leading bytes of a sample that are examined.
    localparam int MAX_BYTES = 4096;
    // Width of a counter that can reach MAX_BYTES itself.
    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    localparam int BYTE_W = 8;
    localparam int ENC_W  = 3;
    localparam int TDATA_W = 8;
    // Number of leading bytes kept for the byte order mark check.
    localparam int HEAD_N = 3;

    // Byte order marks.
    localparam logic [BYTE_W-1:0] BOM8_B0 = 8'hEF;
    localparam logic [BYTE_W-1:0] BOM8_B1 = 8'hBB;
    localparam logic [BYTE_W-1:0] BOM8_B2 = 8'hBF;
    localparam logic [BYTE_W-1:0] BOM16_FF = 8'hFF;
    localparam logic [BYTE_W-1:0] BOM16_FE = 8'hFE;

    // UTF-8 lead and continuation patterns.
    localparam logic [BYTE_W-1:0] UTF8_CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_CONT_VAL   = 8'h80;
    localparam logic [BYTE_W-1:0] UTF8_LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] UTF8_LEAD4_VAL  = 8'hF0;

    // GB2312 lead and trail ranges.
    localparam logic [BYTE_W-1:0] GB_LEAD_MIN  = 8'hA1;
    localparam logic [BYTE_W-1:0] GB_LEAD_MAX  = 8'hF7;
    localparam logic [BYTE_W-1:0] GB_TRAIL_MIN = 8'hA1;
    localparam logic [BYTE_W-1:0] GB_TRAIL_MAX = 8'hFE;

    // Zero skew needs more than this many zero bytes in complete pairs.
    localparam int ZERO_MIN = 4;

    typedef enum logic [ENC_W-1:0] {
        CODE_UTF8_BOM = 3'd0,
        CODE_UTF16_LE = 3'd1,
        CODE_UTF16_BE = 3'd2,
        CODE_UTF8     = 3'd3,
        CODE_GB2312   = 3'd4,
        CODE_LATIN1   = 3'd5,
        CODE_BINARY   = 3'd6
    } t_encoding;

    // Everything the final decision needs, captured at the end of a sample.
    typedef struct packed {
        logic             bom_utf8;
        logic             bom_le;
        logic             bom_be;
        logic [CNT_W-1:0] zero_even;
        logic [CNT_W-1:0] zero_odd;
        logic             utf8_good;
        logic [CNT_W-1:0] gb_pairs;
        logic [CNT_W-1:0] gb_bad;
        logic [CNT_W-1:0] high;
        logic [CNT_W-1:0] len;
    } t_ted_summary;

endpackage

// ----- hw/rtl/text_encoding_detector.sv -----
// Text encoding detector: byte stream in, one encoding code per sample out.
//
//  channel   | dir | tdata                        | tlast / tuser
//  ----------+-----+------------------------------+------------------------------
//  s_axis    | in  | [7:0] data_byte              | tlast = last_byte
//  m_axis    | out | [2:0] encoding, [7:3] zero   | none
//
// One byte request is taken every cycle unless the input is stalled as described
// below. A byte goes into an input register, from there it updates the detector
// counters, and on the last byte of a sample a summary register captures the
// final counts; the priority decision on that summary is then written to the
// output register. Reset (synchronous, active low) clears all detector state;
// the state also returns to its reset values after every sample. Backpressure
// on m_axis only stalls the input when a sample end has to be moved into a full
// summary stage; ordinary bytes keep flowing.
module text_encoding_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [ted_pkg::TDATA_W-1:0]    i_s_axis_tdata,   // [7:0] data_byte
    input  logic                           i_s_axis_tlast,   // last_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [ted_pkg::TDATA_W-1:0]    o_m_axis_tdata    // [2:0] encoding, [7:3] zero
);

    localparam int CNT_W  = ted_pkg::CNT_W;
    localparam int BYTE_W = ted_pkg::BYTE_W;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Detector state.
    logic [CNT_W-1:0]                     r_byte_count, n_byte_count;
    logic [ted_pkg::HEAD_N-1:0][BYTE_W-1:0] r_head, n_head;
    logic                                 r_even_zero_pending, n_even_zero_pending;
    logic [CNT_W-1:0]                     r_zero_even, n_zero_even;
    logic [CNT_W-1:0]                     r_zero_odd, n_zero_odd;
    logic                                 r_utf8_ok, n_utf8_ok;
    logic [1:0]                           r_utf8_pending, n_utf8_pending;
    logic [BYTE_W-1:0]                    r_gb_lead, n_gb_lead;
    logic                                 r_gb_lead_valid, n_gb_lead_valid;
    logic [CNT_W-1:0]                     r_gb_pairs, n_gb_pairs;
    logic [CNT_W-1:0]                     r_gb_bad, n_gb_bad;
    logic [CNT_W-1:0]                     r_high, n_high;

    // Summary stage and output register.
    logic                  r_sum_valid;
    ted_pkg::t_ted_summary r_sum, n_sum;
    logic                  r_out_valid;
    ted_pkg::t_encoding    r_out_enc, n_out_enc;

    // Pipeline control. Only the end of a sample needs room further down.
    logic out_load_ok, sum_free, sum_adv, in_adv;

    assign out_load_ok     = !r_out_valid || i_m_axis_tready;
    assign sum_free        = !r_sum_valid || out_load_ok;
    assign sum_adv         = r_sum_valid && out_load_ok;
    assign in_adv          = r_in_valid && (!r_in_last || sum_free);
    assign o_s_axis_tready = !r_in_valid || in_adv;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(ted_pkg::TDATA_W - ted_pkg::ENC_W)'(0), r_out_enc};

    // Per-byte update of all detectors.
    logic              take;
    logic [BYTE_W-1:0] c;
    logic              gb_pair_ok;

    always_comb begin
        c    = r_in_byte;
        take = (r_byte_count < CNT_W'(ted_pkg::MAX_BYTES));
        gb_pair_ok = (r_gb_lead >= ted_pkg::GB_LEAD_MIN) && (r_gb_lead <= ted_pkg::GB_LEAD_MAX)
                  && (c >= ted_pkg::GB_TRAIL_MIN) && (c <= ted_pkg::GB_TRAIL_MAX);

        n_byte_count        = r_byte_count;
        n_head              = r_head;
        n_even_zero_pending = r_even_zero_pending;
        n_zero_even         = r_zero_even;
        n_zero_odd          = r_zero_odd;
        n_utf8_ok           = r_utf8_ok;
        n_utf8_pending      = r_utf8_pending;
        n_gb_lead           = r_gb_lead;
        n_gb_lead_valid     = r_gb_lead_valid;
        n_gb_pairs          = r_gb_pairs;
        n_gb_bad            = r_gb_bad;
        n_high              = r_high;

        if (take) begin
            n_byte_count = r_byte_count + CNT_W'(1);

            for (int k = 0; k < ted_pkg::HEAD_N; k++) begin
                if (r_byte_count == CNT_W'(k)) begin
                    n_head[k] = c;
                end
            end

            // Zero bytes are counted per complete pair only.
            if (!r_byte_count[0]) begin
                n_even_zero_pending = (c == '0);
            end else begin
                if (r_even_zero_pending) begin
                    n_zero_even = r_zero_even + CNT_W'(1);
                end
                if (c == '0) begin
                    n_zero_odd = r_zero_odd + CNT_W'(1);
                end
                n_even_zero_pending = 1'b0;
            end

            if (r_utf8_pending != 2'd0) begin
                if ((c & ted_pkg::UTF8_CONT_MASK) != ted_pkg::UTF8_CONT_VAL) begin
                    n_utf8_ok = 1'b0;
                end
                n_utf8_pending = r_utf8_pending - 2'd1;
            end else if (c[BYTE_W-1]) begin
                if ((c & ted_pkg::UTF8_LEAD2_MASK) == ted_pkg::UTF8_LEAD2_VAL) begin
                    n_utf8_pending = 2'd1;
                end else if ((c & ted_pkg::UTF8_LEAD3_MASK) == ted_pkg::UTF8_LEAD3_VAL) begin
                    n_utf8_pending = 2'd2;
                end else if ((c & ted_pkg::UTF8_LEAD4_MASK) == ted_pkg::UTF8_LEAD4_VAL) begin
                    n_utf8_pending = 2'd3;
                end else begin
                    n_utf8_ok = 1'b0;
                end
            end

            // A high byte opens a pair unless it completes a valid one.
            if (r_gb_lead_valid && gb_pair_ok) begin
                n_gb_lead_valid = 1'b0;
                n_gb_pairs      = r_gb_pairs + CNT_W'(1);
            end else begin
                if (r_gb_lead_valid) begin
                    n_gb_bad = r_gb_bad + CNT_W'(1);
                end
                n_gb_lead_valid = c[BYTE_W-1];
                if (c[BYTE_W-1]) begin
                    n_gb_lead = c;
                end
            end

            if (c[BYTE_W-1]) begin
                n_high = r_high + CNT_W'(1);
            end
        end

        n_sum.bom_utf8  = (n_head[0] == ted_pkg::BOM8_B0) && (n_head[1] == ted_pkg::BOM8_B1)
                       && (n_head[2] == ted_pkg::BOM8_B2);
        n_sum.bom_le    = (n_head[0] == ted_pkg::BOM16_FF) && (n_head[1] == ted_pkg::BOM16_FE);
        n_sum.bom_be    = (n_head[0] == ted_pkg::BOM16_FE) && (n_head[1] == ted_pkg::BOM16_FF);
        n_sum.zero_even = n_zero_even;
        n_sum.zero_odd  = n_zero_odd;
        n_sum.utf8_good = n_utf8_ok && (n_utf8_pending == 2'd0);
        n_sum.gb_pairs  = n_gb_pairs;
        // An unpaired lead at the end counts as one bad byte.
        n_sum.gb_bad    = n_gb_bad + CNT_W'(n_gb_lead_valid);
        n_sum.high      = n_high;
        n_sum.len       = n_byte_count;
    end

    // Priority decision on the captured summary. The GB2312 ratio test
    // pairs/(pairs+bad) > 0.6 is done exactly as 2*pairs > 3*bad, and the
    // Latin-1 test high > len/10 as 10*high > len.
    logic [CNT_W:0]   zero_sum;
    logic [CNT_W+1:0] ze3, zo3, ze_x, zo_x;
    logic [CNT_W+1:0] gb_pairs2, gb_bad3;
    logic [CNT_W+3:0] high10;
    logic             zero_skew;

    always_comb begin
        zero_sum  = {1'b0, r_sum.zero_even} + {1'b0, r_sum.zero_odd};
        ze_x      = (CNT_W+2)'(r_sum.zero_even);
        zo_x      = (CNT_W+2)'(r_sum.zero_odd);
        ze3       = (ze_x << 1) + ze_x;
        zo3       = (zo_x << 1) + zo_x;
        gb_pairs2 = (CNT_W+2)'(r_sum.gb_pairs) << 1;
        gb_bad3   = ((CNT_W+2)'(r_sum.gb_bad) << 1) + (CNT_W+2)'(r_sum.gb_bad);
        high10    = ((CNT_W+4)'(r_sum.high) << 3) + ((CNT_W+4)'(r_sum.high) << 1);
        zero_skew = (zero_sum > (CNT_W+1)'(ted_pkg::ZERO_MIN)) && ((ze_x > zo3) || (zo_x > ze3));

        if (r_sum.bom_utf8) begin
            n_out_enc = ted_pkg::CODE_UTF8_BOM;
        end else if (r_sum.bom_le) begin
            n_out_enc = ted_pkg::CODE_UTF16_LE;
        end else if (r_sum.bom_be) begin
            n_out_enc = ted_pkg::CODE_UTF16_BE;
        end else if (zero_skew) begin
            n_out_enc = (r_sum.zero_even > r_sum.zero_odd) ? ted_pkg::CODE_UTF16_BE
                                                           : ted_pkg::CODE_UTF16_LE;
        end else if (r_sum.utf8_good) begin
            n_out_enc = ted_pkg::CODE_UTF8;
        end else if ((r_sum.gb_pairs != '0) && (gb_pairs2 > gb_bad3)) begin
            n_out_enc = ted_pkg::CODE_GB2312;
        end else if (high10 > (CNT_W+4)'(r_sum.len)) begin
            n_out_enc = ted_pkg::CODE_LATIN1;
        end else begin
            n_out_enc = ted_pkg::CODE_BINARY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_sum_valid         <= 1'b0;
            r_out_valid         <= 1'b0;
            r_byte_count        <= '0;
            r_head              <= '0;
            r_even_zero_pending <= 1'b0;
            r_zero_even         <= '0;
            r_zero_odd          <= '0;
            r_utf8_ok           <= 1'b1;
            r_utf8_pending      <= 2'd0;
            r_gb_lead           <= '0;
            r_gb_lead_valid     <= 1'b0;
            r_gb_pairs          <= '0;
            r_gb_bad            <= '0;
            r_high              <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    r_in_byte <= i_s_axis_tdata[BYTE_W-1:0];
                    r_in_last <= i_s_axis_tlast;
                end
            end

            if (in_adv) begin
                if (r_in_last) begin
                    // Sample complete: capture the summary, start over.
                    r_sum               <= n_sum;
                    r_byte_count        <= '0;
                    r_head              <= '0;
                    r_even_zero_pending <= 1'b0;
                    r_zero_even         <= '0;
                    r_zero_odd          <= '0;
                    r_utf8_ok           <= 1'b1;
                    r_utf8_pending      <= 2'd0;
                    r_gb_lead           <= '0;
                    r_gb_lead_valid     <= 1'b0;
                    r_gb_pairs          <= '0;
                    r_gb_bad            <= '0;
                    r_high              <= '0;
                end else begin
                    r_byte_count        <= n_byte_count;
                    r_head              <= n_head;
                    r_even_zero_pending <= n_even_zero_pending;
                    r_zero_even         <= n_zero_even;
                    r_zero_odd          <= n_zero_odd;
                    r_utf8_ok           <= n_utf8_ok;
                    r_utf8_pending      <= n_utf8_pending;
                    r_gb_lead           <= n_gb_lead;
                    r_gb_lead_valid     <= n_gb_lead_valid;
                    r_gb_pairs          <= n_gb_pairs;
                    r_gb_bad            <= n_gb_bad;
                    r_high              <= n_high;
                end
            end

            if (in_adv && r_in_last) begin
                r_sum_valid <= 1'b1;
            end else if (sum_adv) begin
                r_sum_valid <= 1'b0;
            end

            if (out_load_ok) begin
                r_out_valid <= r_sum_valid;
                if (r_sum_valid) begin
                    r_out_enc <= n_out_enc;
                end
            end
        end
    end

endmodule
